// ===== hdl/binary_contour_tracer_top_defines.svh =====
// ----------------------------------------------------------------------------
// Binary contour tracer assertion macros
// Shared property forms for the concurrent checks of the contour tracer.
// ----------------------------------------------------------------------------
`ifndef BINARY_CONTOUR_TRACER_TOP_DEFINES_SVH
`define BINARY_CONTOUR_TRACER_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define BCT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define BCT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/bct_pkg.sv =====
// ----------------------------------------------------------------------------
// Binary contour tracer package
// Word types, limits, status codes and the neighbour offset table.
// ----------------------------------------------------------------------------
package bct_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int MAX_STEPS  = 262144;

  localparam int COL_LIMIT = (MAX_WIDTH < 256) ? MAX_WIDTH : 256;
  localparam int ROW_LIMIT = (MAX_HEIGHT < 256) ? MAX_HEIGHT : 256;

  localparam int COORD_W = 8;
  localparam int DIM_W   = 9;
  localparam int ADDR_W  = 2 * COORD_W;
  localparam int CNT_W   = $clog2(MAX_STEPS + 1);

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_STEP = 1'b1;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;

  typedef enum logic [2:0] {
    ST_POINT    = 3'd0,
    ST_CLOSE    = 3'd1,
    ST_NONE     = 3'd2,
    ST_ABORT    = 3'd3,
    ST_FINISHED = 3'd4
  } status_t;

  typedef struct packed {
    logic               action;
    logic [COORD_W-1:0] pixel_col;
    logic [COORD_W-1:0] pixel_row;
    logic               pixel_on;
  } item_t;

  typedef struct packed {
    logic [COORD_W-1:0] point_col;
    logic [COORD_W-1:0] point_row;
    status_t            status;
  } result_t;

  typedef struct packed {
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic               in_bounds;
  } probe_t;

  // Column offset of each direction, as a ten-bit two's complement value.
  function automatic logic [DIM_W:0] nbr_dx(input logic [2:0] dir);
    logic [DIM_W:0] off;
    case (dir)
      3'd0, 3'd6, 3'd7: off = '1;
      3'd1, 3'd5:       off = '0;
      default:          off = (DIM_W + 1)'(1);
    endcase
    return off;
  endfunction

  // Row offset of each direction, as a ten-bit two's complement value.
  function automatic logic [DIM_W:0] nbr_dy(input logic [2:0] dir);
    logic [DIM_W:0] off;
    case (dir)
      3'd0, 3'd1, 3'd2: off = (DIM_W + 1)'(1);
      3'd3, 3'd7:       off = '0;
      default:          off = '1;
    endcase
    return off;
  endfunction

endpackage

// ===== hdl/bct_image_mem.sv =====
// ----------------------------------------------------------------------------
// Binary contour tracer image memory
// One-bit image store with one write port and one registered read port.
// ----------------------------------------------------------------------------
module bct_image_mem (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [bct_pkg::ADDR_W-1:0] wr_addr,
  input  logic                      wr_data,
  input  logic [bct_pkg::ADDR_W-1:0] rd_addr,
  output logic                      rd_data
);

  logic mem [0:(1 << bct_pkg::ADDR_W)-1];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== hdl/bct_nbr_unit.sv =====
// ----------------------------------------------------------------------------
// Binary contour tracer neighbour unit
// Shared adder and bounds compare that locates one neighbour of a point.
// ----------------------------------------------------------------------------
module bct_nbr_unit (
  input  logic [bct_pkg::COORD_W-1:0] cur_col,
  input  logic [bct_pkg::COORD_W-1:0] cur_row,
  input  logic [2:0]                  dir,
  input  logic [bct_pkg::DIM_W-1:0]   width,
  input  logic [bct_pkg::DIM_W-1:0]   height,
  output bct_pkg::probe_t             probe
);

  logic [bct_pkg::DIM_W:0] sum_col;
  logic [bct_pkg::DIM_W:0] sum_row;

  assign sum_col = {2'b00, cur_col} + bct_pkg::nbr_dx(dir);
  assign sum_row = {2'b00, cur_row} + bct_pkg::nbr_dy(dir);

  assign probe.col       = sum_col[bct_pkg::COORD_W-1:0];
  assign probe.row       = sum_row[bct_pkg::COORD_W-1:0];
  assign probe.in_bounds = !sum_col[bct_pkg::DIM_W] &&
                           (sum_col[bct_pkg::DIM_W-1:0] < width) &&
                           !sum_row[bct_pkg::DIM_W] &&
                           (sum_row[bct_pkg::DIM_W-1:0] < height);

endmodule

// ===== hdl/binary_contour_tracer_top.sv =====
// ----------------------------------------------------------------------------
// Binary contour tracer
// Moore neighbour contour tracing over a loaded one-bit image.
// ----------------------------------------------------------------------------
//  Channel  Signals                           Word
//  item     item_valid, item_stall, item      load one pixel or advance one step
//  result   result_valid, result_stall, result  traced point and status
//  cfg      cfg_valid, cfg_ready, cfg_index,  image width and height
//           cfg_data
//
// A load is written to the image memory as it is taken in. A step that
// continues a trace has its result after the neighbour probes, and the next
// word is not taken in until that result is handed over: the probes share the
// single read port of the image memory, one per cycle, and the result passes
// through S_RESULT into the output register. The first step of a trace scans
// the image in raster order, one pixel a cycle, before its move begins.
// Reset clears the control state and restores a 256 by 256 image; the image
// memory itself is not cleared. A stalled result is held in the output
// register while the next word may already be taken in; the item channel also
// stalls while a configuration write is offered.
// ----------------------------------------------------------------------------
`include "binary_contour_tracer_top_defines.svh"

module binary_contour_tracer_top (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      item_valid,
  output logic                      item_stall,
  input  bct_pkg::item_t            item,
  output logic                      result_valid,
  input  logic                      result_stall,
  output bct_pkg::result_t          result,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [1:0]                cfg_index,
  input  logic [bct_pkg::DIM_W-1:0] cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_PROBE  = 4'b0100,
    S_RESULT = 4'b1000
  } state_t;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'b001,
    PH_TRACE = 3'b010,
    PH_DONE  = 3'b100
  } phase_t;

  localparam logic [bct_pkg::DIM_W-1:0] COL_LIM = bct_pkg::DIM_W'(bct_pkg::COL_LIMIT);
  localparam logic [bct_pkg::DIM_W-1:0] ROW_LIM = bct_pkg::DIM_W'(bct_pkg::ROW_LIMIT);
  localparam logic [bct_pkg::CNT_W-1:0] MAX_CNT = bct_pkg::CNT_W'(bct_pkg::MAX_STEPS);
  localparam logic [bct_pkg::DIM_W-1:0] DIM_ONE = bct_pkg::DIM_W'(1);

  state_t                      state;
  phase_t                      phase;
  logic [bct_pkg::DIM_W-1:0]   w_lim;
  logic [bct_pkg::DIM_W-1:0]   h_lim;
  logic [bct_pkg::COORD_W-1:0] cur_col;
  logic [bct_pkg::COORD_W-1:0] cur_row;
  logic [bct_pkg::COORD_W-1:0] start_col;
  logic [bct_pkg::COORD_W-1:0] start_row;
  logic [2:0]                  dir;
  logic [bct_pkg::CNT_W-1:0]   cnt;
  logic [bct_pkg::COORD_W-1:0] sc;
  logic [bct_pkg::COORD_W-1:0] sr;
  logic [2:0]                  iss_dir;
  logic [2:0]                  k;
  logic                        pend;
  logic                        pend_inb;
  logic                        pend_last;
  logic [2:0]                  pend_dir;
  logic [bct_pkg::COORD_W-1:0] pend_col;
  logic [bct_pkg::COORD_W-1:0] pend_row;
  bct_pkg::result_t            res_buf;

  logic                        accept;
  logic                        cfg_wr;
  logic [bct_pkg::DIM_W-1:0]   cfg_clamped;
  logic                        rd_data;
  logic [bct_pkg::ADDR_W-1:0]  rd_addr;
  bct_pkg::probe_t             nb;
  logic                        col_end;
  logic                        scan_last;
  logic                        hit;
  logic                        probe_end;
  logic [bct_pkg::COORD_W-1:0] col_next;
  logic [bct_pkg::COORD_W-1:0] row_next;
  logic [bct_pkg::CNT_W-1:0]   cnt_next;
  bct_pkg::status_t            status_next;

  assign item_stall = (state != S_IDLE) || cfg_valid;
  assign cfg_ready  = (state == S_IDLE);
  assign accept     = item_valid && !item_stall;
  assign cfg_wr     = cfg_valid && cfg_ready;

  always_comb begin
    if (cfg_data == '0) begin
      cfg_clamped = DIM_ONE;
    end else if ((cfg_index == bct_pkg::REG_WIDTH) && (cfg_data > COL_LIM)) begin
      cfg_clamped = COL_LIM;
    end else if ((cfg_index == bct_pkg::REG_HEIGHT) && (cfg_data > ROW_LIM)) begin
      cfg_clamped = ROW_LIM;
    end else begin
      cfg_clamped = cfg_data;
    end
  end

  bct_image_mem u_mem (
    .clk     (clk),
    .wr_en   (accept && (item.action == bct_pkg::ACT_LOAD)),
    .wr_addr ({item.pixel_row, item.pixel_col}),
    .wr_data (item.pixel_on),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  bct_nbr_unit u_nbr (
    .cur_col (cur_col),
    .cur_row (cur_row),
    .dir     (iss_dir),
    .width   (w_lim),
    .height  (h_lim),
    .probe   (nb)
  );

  assign rd_addr   = (state == S_PROBE) ? {nb.row, nb.col} : {sr, sc};
  assign col_end   = (({1'b0, sc} + DIM_ONE) == w_lim);
  assign scan_last = col_end && (({1'b0, sr} + DIM_ONE) == h_lim);
  assign hit       = pend && pend_inb && rd_data;
  assign probe_end = hit || (pend && pend_last);
  assign col_next  = hit ? pend_col : cur_col;
  assign row_next  = hit ? pend_row : cur_row;
  assign cnt_next  = (cnt < MAX_CNT) ? cnt + 1'b1 : cnt;

  always_comb begin
    if ((col_next == start_col) && (row_next == start_row)) begin
      status_next = bct_pkg::ST_CLOSE;
    end else if (cnt_next >= MAX_CNT) begin
      status_next = bct_pkg::ST_ABORT;
    end else begin
      status_next = bct_pkg::ST_POINT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      phase        <= PH_IDLE;
      w_lim        <= COL_LIM;
      h_lim        <= ROW_LIM;
      cur_col      <= '0;
      cur_row      <= '0;
      start_col    <= '0;
      start_row    <= '0;
      dir          <= '0;
      cnt          <= '0;
      pend         <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if ((state == S_RESULT) && (!result_valid || !result_stall)) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cfg_wr) begin
            if (cfg_index == bct_pkg::REG_WIDTH) begin
              w_lim <= cfg_clamped;
              phase <= PH_IDLE;
              cnt   <= '0;
            end else if (cfg_index == bct_pkg::REG_HEIGHT) begin
              h_lim <= cfg_clamped;
              phase <= PH_IDLE;
              cnt   <= '0;
            end
          end
          if (accept) begin
            pend <= 1'b0;
            if (item.action == bct_pkg::ACT_LOAD) begin
              phase <= PH_IDLE;
              cnt   <= '0;
            end else if (phase == PH_DONE) begin
              res_buf <= '{point_col: '0, point_row: '0, status: bct_pkg::ST_FINISHED};
              state   <= S_RESULT;
            end else if (phase == PH_TRACE) begin
              iss_dir <= dir;
              k       <= '0;
              state   <= S_PROBE;
            end else begin
              sc    <= '0;
              sr    <= '0;
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (hit) begin
            start_col <= pend_col;
            start_row <= pend_row;
            cur_col   <= pend_col;
            cur_row   <= pend_row;
            dir       <= '0;
            iss_dir   <= '0;
            k         <= '0;
            cnt       <= '0;
            pend      <= 1'b0;
            phase     <= PH_TRACE;
            state     <= S_PROBE;
          end else if (pend && pend_last) begin
            res_buf <= '{point_col: '0, point_row: '0, status: bct_pkg::ST_NONE};
            pend    <= 1'b0;
            state   <= S_RESULT;
          end else begin
            pend      <= 1'b1;
            pend_inb  <= 1'b1;
            pend_last <= scan_last;
            pend_col  <= sc;
            pend_row  <= sr;
            if (col_end) begin
              sc <= '0;
              sr <= sr + 1'b1;
            end else begin
              sc <= sc + 1'b1;
            end
          end
        end
        S_PROBE: begin
          if (probe_end) begin
            cur_col <= col_next;
            cur_row <= row_next;
            dir     <= pend_dir + 3'd6;
            cnt     <= cnt_next;
            pend    <= 1'b0;
            if (status_next != bct_pkg::ST_POINT) begin
              phase <= PH_DONE;
            end
            res_buf <= '{point_col: col_next, point_row: row_next, status: status_next};
            state   <= S_RESULT;
          end else begin
            pend      <= 1'b1;
            pend_inb  <= nb.in_bounds;
            pend_last <= (k == 3'd7);
            pend_dir  <= iss_dir;
            pend_col  <= nb.col;
            pend_row  <= nb.row;
            iss_dir   <= iss_dir + 1'b1;
            k         <= k + 1'b1;
          end
        end
        S_RESULT: begin
          if (!result_valid || !result_stall) begin
            result <= res_buf;
            state  <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `BCT_ASSERT_IMP(a_probe_in_trace, state == S_PROBE, phase == PH_TRACE,
                  "Neighbour probing outside an active trace")
  `BCT_ASSERT_IMP(a_cnt_bound, phase != PH_DONE, cnt < MAX_CNT,
                  "Step count reached the bound without ending the trace")
  `BCT_ASSERT_NXT(a_finished_reply,
                  accept && (item.action == bct_pkg::ACT_STEP) && (phase == PH_DONE),
                  (state == S_RESULT) && (res_buf.status == bct_pkg::ST_FINISHED),
                  "Step after a finished trace did not answer as finished")
  `BCT_ASSERT_NXT(a_result_handover,
                  (state == S_RESULT) && (!result_valid || !result_stall),
                  result_valid && (state == S_IDLE),
                  "Pending result was not moved to the output register")

endmodule
